/* hdl/atc_pkg.sv */
// ----------------------------------------------------------------------------
// Alert table package
// Entry, item and result types, item kind and outcome codes, band codes and
// sequencer states shared by the alert table modules.
// ----------------------------------------------------------------------------
package atc_pkg;

    // Item kinds.
    localparam logic [2:0] KIND_ADD      = 3'd0;
    localparam logic [2:0] KIND_RES_SLOT = 3'd1;
    localparam logic [2:0] KIND_RES_ID   = 3'd2;
    localparam logic [2:0] KIND_CLEAR    = 3'd3;
    localparam logic [2:0] KIND_READ     = 3'd4;

    // Outcome codes.
    localparam logic [1:0] OUT_OK       = 2'd0;
    localparam logic [1:0] OUT_FULL     = 2'd1;
    localparam logic [1:0] OUT_BAD_SLOT = 2'd2;
    localparam logic [1:0] OUT_ID_MISS  = 2'd3;

    // Severity bands.
    localparam logic [1:0] BAND_LOW    = 2'd0;
    localparam logic [1:0] BAND_MEDIUM = 2'd1;
    localparam logic [1:0] BAND_HIGH   = 2'd2;

    // Configuration register indexes.
    localparam int         CFG_IDX_W = 1;
    localparam logic [0:0] CFG_LOW   = 1'd0;
    localparam logic [0:0] CFG_MED   = 1'd1;

    localparam logic [6:0] LOW_RESET = 7'd33;
    localparam logic [6:0] MED_RESET = 7'd66;
    localparam logic [6:0] SEV_MAX   = 7'd100;

    localparam int SLOT_W    = 4;
    localparam int OUT_CNT_W = 5;

    typedef struct packed {
        logic [31:0] alert_id;
        logic [15:0] node_number;
        logic [7:0]  resource_kind;
        logic [6:0]  severity;
        logic [31:0] time_stamp;
        logic        resolved;
    } t_entry;

    typedef struct packed {
        logic [2:0]        kind;
        logic [31:0]       alert_id;
        logic [15:0]       node_number;
        logic [7:0]        resource_kind;
        logic [6:0]        severity;
        logic [31:0]       time_stamp;
        logic              entry_resolved;
        logic [SLOT_W-1:0] slot;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           outcome;
        logic [OUT_CNT_W-1:0] entry_count;
        logic [OUT_CNT_W-1:0] active_count;
        logic [31:0]          out_alert_id;
        logic [15:0]          out_node_number;
        logic [7:0]           out_resource_kind;
        logic [6:0]           out_severity;
        logic [31:0]          out_time_stamp;
        logic                 out_resolved;
        logic [1:0]           severity_band;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CMP_RD,
        ST_CMP_WR,
        ST_ADD,
        ST_SLOT_RD,
        ST_SLOT_WR,
        ST_ID_RD,
        ST_ID_CHK,
        ST_READ_RD,
        ST_READ_OUT,
        ST_DONE
    } t_state;

endpackage

/* hdl/atc_chan_if.sv */
// ----------------------------------------------------------------------------
// Alert table channel
// Valid/ready channel that carries one payload beat.
// ----------------------------------------------------------------------------
interface atc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/alert_table_with_compaction_top.sv */
// ----------------------------------------------------------------------------
// Alert table with compaction
// Table of alert entries with add, resolve, compaction and read, run by a
// small sequencer around one entry memory and one shared pointer comparator.
// ----------------------------------------------------------------------------
// A result waits while the output register still holds a beat that has not been taken.
// Throughput: one item at a time; the input is ready again in the cycle after the
// result is loaded into the output register. Reset: counts and output valid clear,
// band limits return to 33 and 66; the entry memory is not cleared.
module alert_table_with_compaction_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [atc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [6:0]                   i_cfg_data,
    atc_chan_if.sink                     i_item,
    atc_chan_if.source                   o_result
);
    // Pointers and counts hold 0..TABLE_DEPTH; memory addresses hold only
    // 0..TABLE_DEPTH-1. The shared comparator works at the wider of count and slot width.
    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > atc_pkg::SLOT_W) ? CNT_W : atc_pkg::SLOT_W;

    atc_pkg::t_state    r_state, n_state;
    atc_pkg::t_in_item  r_item, n_item;
    logic [CNT_W-1:0]   r_ptr, n_ptr;
    logic [CNT_W-1:0]   r_wp, n_wp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_active, n_active;
    logic [1:0]         r_outcome, n_outcome;
    atc_pkg::t_entry    r_res_entry, n_res_entry;
    logic [1:0]         r_res_band, n_res_band;
    logic               r_out_valid, n_out_valid;
    atc_pkg::t_out_item r_out_data, n_out_data;
    logic [6:0]         r_low, r_med;

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    atc_pkg::t_entry    mem_wdata;
    logic [ADDR_W-1:0]  mem_raddr;
    atc_pkg::t_entry    rd_data;

    logic [CMP_W-1:0]   cmp_a, cmp_b;
    logic               cmp_lt;
    logic [CMP_W-1:0]   slot_ext, ptr_ext, count_ext;
    logic               full;
    logic [1:0]         band;
    logic [6:0]         sev_sat;

    // Entry memory: one write and one registered read per cycle.
    atc_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // The band of a read entry is taken from the registered read data.
    atc_band u_band (
        .i_severity (rd_data.severity),
        .i_low_max  (r_low),
        .i_med_max  (r_med),
        .o_band     (band)
    );

    assign slot_ext  = CMP_W'(r_item.slot);
    assign ptr_ext   = CMP_W'(r_ptr);
    assign count_ext = CMP_W'(r_count);
    assign cmp_lt    = (cmp_a < cmp_b);
    assign full      = (r_count == CNT_W'(TABLE_DEPTH));
    assign sev_sat   = (r_item.severity > atc_pkg::SEV_MAX) ? atc_pkg::SEV_MAX
                                                            : r_item.severity;

    assign i_item.ready   = (r_state == atc_pkg::ST_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= atc_pkg::ST_IDLE;
            r_count     <= '0;
            r_active    <= '0;
            r_out_valid <= 1'b0;
            r_low       <= atc_pkg::LOW_RESET;
            r_med       <= atc_pkg::MED_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    atc_pkg::CFG_LOW: r_low <= i_cfg_data;
                    atc_pkg::CFG_MED: r_med <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_ptr       <= n_ptr;
        r_wp        <= n_wp;
        r_outcome   <= n_outcome;
        r_res_entry <= n_res_entry;
        r_res_band  <= n_res_band;
        r_out_data  <= n_out_data;
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_ptr       = r_ptr;
        n_wp        = r_wp;
        n_count     = r_count;
        n_active    = r_active;
        n_outcome   = r_outcome;
        n_res_entry = r_res_entry;
        n_res_band  = r_res_band;
        n_out_data  = r_out_data;
        n_out_valid = r_out_valid && !o_result.ready;

        mem_we    = 1'b0;
        mem_waddr = r_wp[ADDR_W-1:0];
        mem_wdata = rd_data;
        mem_raddr = r_ptr[ADDR_W-1:0];

        // The comparator checks the walk pointer against the entry count
        // unless the slot of the item is being range checked.
        cmp_a = ptr_ext;
        cmp_b = count_ext;

        case (r_state)
            atc_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_item  = i_item.data;
                    n_state = atc_pkg::ST_DISPATCH;
                end
            end

            atc_pkg::ST_DISPATCH: begin
                n_outcome   = atc_pkg::OUT_OK;
                n_res_entry = '0;
                n_res_band  = atc_pkg::BAND_LOW;
                n_ptr       = '0;
                n_wp        = '0;
                cmp_a       = slot_ext;
                case (r_item.kind)
                    atc_pkg::KIND_ADD: begin
                        n_state = full ? atc_pkg::ST_CMP_RD : atc_pkg::ST_ADD;
                    end
                    atc_pkg::KIND_RES_SLOT: begin
                        if (cmp_lt) begin
                            n_ptr   = slot_ext[CNT_W-1:0];
                            n_state = atc_pkg::ST_SLOT_RD;
                        end else begin
                            n_outcome = atc_pkg::OUT_BAD_SLOT;
                            n_state   = atc_pkg::ST_DONE;
                        end
                    end
                    atc_pkg::KIND_RES_ID: begin
                        n_state = atc_pkg::ST_ID_RD;
                    end
                    atc_pkg::KIND_CLEAR: begin
                        n_state = atc_pkg::ST_CMP_RD;
                    end
                    atc_pkg::KIND_READ: begin
                        if (cmp_lt) begin
                            n_ptr   = slot_ext[CNT_W-1:0];
                            n_state = atc_pkg::ST_READ_RD;
                        end else begin
                            n_outcome = atc_pkg::OUT_BAD_SLOT;
                            n_state   = atc_pkg::ST_DONE;
                        end
                    end
                    default: begin
                        n_state = atc_pkg::ST_DONE;
                    end
                endcase
            end

            // Compaction: r_ptr walks every held entry, r_wp marks where the
            // next active entry lands. Each entry takes a read and a write turn.
            atc_pkg::ST_CMP_RD: begin
                if (cmp_lt) begin
                    n_state = atc_pkg::ST_CMP_WR;
                end else begin
                    n_count  = r_wp;
                    n_active = r_wp;
                    n_state  = (r_item.kind == atc_pkg::KIND_ADD) ? atc_pkg::ST_ADD
                                                                  : atc_pkg::ST_DONE;
                end
            end

            atc_pkg::ST_CMP_WR: begin
                if (!rd_data.resolved) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wp[ADDR_W-1:0];
                    mem_wdata = rd_data;
                    n_wp      = r_wp + 1'b1;
                end
                n_ptr   = r_ptr + 1'b1;
                n_state = atc_pkg::ST_CMP_RD;
            end

            atc_pkg::ST_ADD: begin
                if (full) begin
                    n_outcome = atc_pkg::OUT_FULL;
                end else begin
                    mem_we                  = 1'b1;
                    mem_waddr               = r_count[ADDR_W-1:0];
                    mem_wdata.alert_id      = r_item.alert_id;
                    mem_wdata.node_number   = r_item.node_number;
                    mem_wdata.resource_kind = r_item.resource_kind;
                    mem_wdata.severity      = sev_sat;
                    mem_wdata.time_stamp    = r_item.time_stamp;
                    mem_wdata.resolved      = r_item.entry_resolved;
                    n_count                 = r_count + 1'b1;
                    if (!r_item.entry_resolved) begin
                        n_active = r_active + 1'b1;
                    end
                end
                n_state = atc_pkg::ST_DONE;
            end

            atc_pkg::ST_SLOT_RD: begin
                n_state = atc_pkg::ST_SLOT_WR;
            end

            atc_pkg::ST_SLOT_WR: begin
                mem_we             = 1'b1;
                mem_waddr          = r_ptr[ADDR_W-1:0];
                mem_wdata          = rd_data;
                mem_wdata.resolved = 1'b1;
                if (!rd_data.resolved) begin
                    n_active = r_active - 1'b1;
                end
                n_state = atc_pkg::ST_DONE;
            end

            atc_pkg::ST_ID_RD: begin
                if (cmp_lt) begin
                    n_state = atc_pkg::ST_ID_CHK;
                end else begin
                    n_outcome = atc_pkg::OUT_ID_MISS;
                    n_state   = atc_pkg::ST_DONE;
                end
            end

            atc_pkg::ST_ID_CHK: begin
                if (rd_data.alert_id == r_item.alert_id) begin
                    mem_we             = 1'b1;
                    mem_waddr          = r_ptr[ADDR_W-1:0];
                    mem_wdata          = rd_data;
                    mem_wdata.resolved = 1'b1;
                    if (!rd_data.resolved) begin
                        n_active = r_active - 1'b1;
                    end
                    n_state = atc_pkg::ST_DONE;
                end else begin
                    n_ptr   = r_ptr + 1'b1;
                    n_state = atc_pkg::ST_ID_RD;
                end
            end

            atc_pkg::ST_READ_RD: begin
                n_state = atc_pkg::ST_READ_OUT;
            end

            atc_pkg::ST_READ_OUT: begin
                n_res_entry = rd_data;
                n_res_band  = band;
                n_state     = atc_pkg::ST_DONE;
            end

            // The result waits here only while the output register still
            // holds a beat that has not been taken.
            atc_pkg::ST_DONE: begin
                if (!r_out_valid || o_result.ready) begin
                    n_out_valid                  = 1'b1;
                    n_out_data.outcome           = r_outcome;
                    n_out_data.entry_count       = atc_pkg::OUT_CNT_W'(r_count);
                    n_out_data.active_count      = atc_pkg::OUT_CNT_W'(r_active);
                    n_out_data.out_alert_id      = r_res_entry.alert_id;
                    n_out_data.out_node_number   = r_res_entry.node_number;
                    n_out_data.out_resource_kind = r_res_entry.resource_kind;
                    n_out_data.out_severity      = r_res_entry.severity;
                    n_out_data.out_time_stamp    = r_res_entry.time_stamp;
                    n_out_data.out_resolved      = r_res_entry.resolved;
                    n_out_data.severity_band     = r_res_band;
                    n_state                      = atc_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = atc_pkg::ST_IDLE;
            end
        endcase
    end

    // Never more active entries than held entries.
    a_active_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active <= r_count)
        else $error("active count exceeds entry count");

    // The table never holds more than its depth.
    a_count_le_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // During compaction the write pointer never passes the read pointer.
    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atc_pkg::ST_CMP_RD || r_state == atc_pkg::ST_CMP_WR)
        |-> (r_wp <= r_ptr))
        else $error("compaction write pointer ahead of read pointer");

    // A rejected add means compaction left a full table of active entries.
    a_full_all_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == atc_pkg::ST_DONE && r_item.kind == atc_pkg::KIND_ADD
         && r_outcome == atc_pkg::OUT_FULL)
        |-> (full && r_active == r_count))
        else $error("add rejected while table holds resolved entries");

endmodule

/* hdl/atc_store.sv */
// ----------------------------------------------------------------------------
// Alert table entry store
// Single write port, single read port entry memory with registered read data.
// ----------------------------------------------------------------------------
module atc_store #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_waddr,
    input  atc_pkg::t_entry                i_wdata,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_raddr,
    output atc_pkg::t_entry                o_rdata
);
    atc_pkg::t_entry r_mem [TABLE_DEPTH];
    atc_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hdl/atc_band.sv */
// ----------------------------------------------------------------------------
// Alert table severity band
// Classes a severity as low, medium or high against the two band limits.
// ----------------------------------------------------------------------------
module atc_band (
    input  logic [6:0] i_severity,
    input  logic [6:0] i_low_max,
    input  logic [6:0] i_med_max,
    output logic [1:0] o_band
);
    // The low limit is tested first, so limits out of order still give a
    // defined band.
    always_comb begin
        if (i_severity <= i_low_max) begin
            o_band = atc_pkg::BAND_LOW;
        end else if (i_severity <= i_med_max) begin
            o_band = atc_pkg::BAND_MEDIUM;
        end else begin
            o_band = atc_pkg::BAND_HIGH;
        end
    end
endmodule
